### design/cst_pkg.sv
package cst_pkg;

   // default lexeme size bound, the length saturates one below it (at most 255)
   localparam int CST_MAX_LEXEME = 256;

   // result queue between the scanner and the output port
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [23:0] POS_MAX  = 24'hFF_FFFF;
   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   // characters with a role in the scan
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINEC,
      MODE_BLOCKC,
      MODE_NUM,
      MODE_IDENT,
      MODE_STR,
      MODE_CHR
   } mode_type;

   typedef enum logic [4:0] {
      KIND_EOF    = 5'd0,
      KIND_NUM    = 5'd1,
      KIND_IDENT  = 5'd2,
      KIND_INT    = 5'd3,
      KIND_RETURN = 5'd4,
      KIND_IF     = 5'd5,
      KIND_ELSE   = 5'd6,
      KIND_WHILE  = 5'd7,
      KIND_STR    = 5'd8,
      KIND_CHR    = 5'd9,
      KIND_PLUS   = 5'd10,
      KIND_MINUS  = 5'd11,
      KIND_STAR   = 5'd12,
      KIND_SLASH  = 5'd13,
      KIND_ASSIGN = 5'd14,
      KIND_LPAREN = 5'd15,
      KIND_RPAREN = 5'd16,
      KIND_LBRACE = 5'd17,
      KIND_RBRACE = 5'd18,
      KIND_SEMI   = 5'd19,
      KIND_ERR    = 5'd20
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_UNEXPECTED  = 3'd1,
      ERR_OPEN_COMM   = 3'd2,
      ERR_OPEN_STR    = 3'd3,
      ERR_OPEN_CHR    = 3'd4,
      ERR_TOO_LONG    = 3'd5
   } err_type;

   typedef struct packed {
      kind_type    kind;
      err_type     err;
      logic [23:0] start_pos;
      logic [7:0]  length;
      logic [15:0] start_line;
      logic [7:0]  bad_char;
      logic        last;
   } tok_rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic        star_seen;
      logic [23:0] tok_start;
      logic [7:0]  tok_len;
      logic        len_ovf;
      logic [4:0]  kw_cand;
      logic [15:0] line_cnt;
      logic [23:0] byte_pos;
      logic [15:0] tok_line;
   } scan_state_type;

   // results of one accepted byte
   typedef struct packed {
      logic [1:0]  cnt;
      tok_rsp_type r0;
      tok_rsp_type r1;
   } scan_out_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:      MODE_IDLE,
      star_seen: 1'b0,
      tok_start: 24'd0,
      tok_len:   8'd0,
      len_ovf:   1'b0,
      kw_cand:   5'b11111,
      line_cnt:  16'd1,
      byte_pos:  24'd0,
      tok_line:  16'd1
   };

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_USCORE);
   endfunction

   // single-byte operators and delimiters, anything else is unexpected
   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h3D:   k = KIND_ASSIGN;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h3B:   k = KIND_SEMI;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

   // keyword lengths in order int, return, if, else, while
   function automatic logic [7:0] kw_len(input logic [2:0] k);
      logic [7:0] n;
      case (k)
         3'd0:    n = 8'd3;
         3'd1:    n = 8'd6;
         3'd2:    n = 8'd2;
         3'd3:    n = 8'd4;
         3'd4:    n = 8'd5;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

   // character at idx of keyword k, zero past its end
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [7:0] idx);
      logic [47:0] txt;
      logic [47:0] sh;
      case (k)
         3'd0:    txt = {"int", 24'h0};
         3'd1:    txt = "return";
         3'd2:    txt = {"if", 32'h0};
         3'd3:    txt = {"else", 16'h0};
         3'd4:    txt = {"while", 8'h0};
         default: txt = 48'h0;
      endcase
      sh = txt << {idx[2:0], 3'b000};
      return (idx > 8'd5) ? 8'h00 : sh[47:40];
   endfunction

   function automatic tok_rsp_type make_rsp(input kind_type kind, input err_type err,
                                            input logic [23:0] pos, input logic [7:0] len,
                                            input logic [15:0] line, input logic [7:0] bad);
      tok_rsp_type r;
      r.kind       = kind;
      r.err        = err;
      r.start_pos  = pos;
      r.length     = len;
      r.start_line = line;
      r.bad_char   = bad;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

### design/cst_scan.sv
module cst_scan
   import cst_pkg::*;
#(
   parameter int MAX_LEXEME = CST_MAX_LEXEME
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_valid,
   input  logic [7:0]   step_ch,
   output scan_out_type scan_out
);

   localparam int LexLimitI = (MAX_LEXEME - 1 > 255) ? 255 : MAX_LEXEME - 1;
   localparam logic [7:0] LexLimit = 8'(LexLimitI);

   scan_state_type state_ff;
   scan_state_type state_in;

   function automatic scan_state_type grow(input scan_state_type s);
      scan_state_type t;
      t = s;
      if (t.tok_len < LexLimit) begin
         t.tok_len = t.tok_len + 8'd1;
      end else begin
         t.len_ovf = 1'b1;
      end
      return t;
   endfunction

   function automatic scan_state_type ident_byte(input scan_state_type s, input logic [7:0] c);
      scan_state_type t;
      t = s;
      for (int k = 0; k < 5; k++) begin
         if (t.tok_len >= kw_len(3'(k)) || kw_char(3'(k), t.tok_len) != c) begin
            t.kw_cand[k] = 1'b0;
         end
      end
      return grow(t);
   endfunction

   function automatic scan_state_type begin_tok(input scan_state_type s);
      scan_state_type t;
      t = s;
      t.tok_start = s.byte_pos;
      t.tok_line  = s.line_cnt;
      t.tok_len   = 8'd0;
      t.len_ovf   = 1'b0;
      t.kw_cand   = 5'b11111;
      return t;
   endfunction

   scan_state_type cur;
   scan_state_type nx;
   scan_state_type idle_st;
   logic           idle_has;
   tok_rsp_type    idle_res;
   logic           pre_has;
   tok_rsp_type    pre_res;
   logic           use_idle;
   kind_type       id_kind;
   logic           found;
   err_type        tok_err;
   logic [7:0]     c;
   scan_out_type   out_c;

   always_comb begin
      c        = step_ch;
      cur      = state_ff;
      tok_err  = cur.len_ovf ? ERR_TOO_LONG : ERR_NONE;

      // what a byte does between tokens
      idle_st      = cur;
      idle_st.mode = MODE_IDLE;
      idle_has     = 1'b0;
      idle_res     = make_rsp(KIND_EOF, ERR_NONE, cur.byte_pos, 8'd0, cur.line_cnt, 8'd0);
      if (c == CH_NUL) begin
         idle_has = 1'b1;
      end else if (is_space(c)) begin
         idle_has = 1'b0;
      end else if (c == CH_SLASH) begin
         idle_st      = begin_tok(idle_st);
         idle_st.mode = MODE_SLASH;
      end else if (is_digit(c)) begin
         idle_st      = grow(begin_tok(idle_st));
         idle_st.mode = MODE_NUM;
      end else if (is_alpha(c)) begin
         idle_st      = ident_byte(begin_tok(idle_st), c);
         idle_st.mode = MODE_IDENT;
      end else if (c == CH_DQUOTE) begin
         idle_st      = begin_tok(idle_st);
         idle_st.mode = MODE_STR;
      end else if (c == CH_SQUOTE) begin
         idle_st      = begin_tok(idle_st);
         idle_st.mode = MODE_CHR;
      end else if (single_kind(c) != KIND_ERR) begin
         idle_has = 1'b1;
         idle_res = make_rsp(single_kind(c), ERR_NONE, cur.byte_pos, 8'd1, cur.line_cnt,
                             8'd0);
      end else begin
         idle_has = 1'b1;
         idle_res = make_rsp(KIND_ERR, ERR_UNEXPECTED, cur.byte_pos, 8'd1, cur.line_cnt, c);
      end

      // keyword pick for a finished word
      id_kind = KIND_IDENT;
      found   = 1'b0;
      if (!cur.len_ovf) begin
         for (int k = 0; k < 5; k++) begin
            if (!found && cur.kw_cand[k] && cur.tok_len == kw_len(3'(k))) begin
               id_kind = kind_type'(5'(KIND_INT) + 5'(k));
               found   = 1'b1;
            end
         end
      end

      // mode transitions
      nx       = cur;
      use_idle = 1'b0;
      pre_has  = 1'b0;
      pre_res  = make_rsp(KIND_ERR, ERR_NONE, cur.tok_start, cur.tok_len, cur.tok_line, 8'd0);
      case (cur.mode)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               nx.mode = MODE_LINEC;
            end else if (c == CH_STAR) begin
               nx.mode      = MODE_BLOCKC;
               nx.star_seen = 1'b0;
            end else begin
               pre_has  = 1'b1;
               pre_res  = make_rsp(KIND_SLASH, ERR_NONE, cur.tok_start, 8'd1, cur.tok_line,
                                   8'd0);
               use_idle = 1'b1;
            end
         end
         MODE_LINEC: begin
            use_idle = (c == CH_NUL) || (c == CH_NL);
         end
         MODE_BLOCKC: begin
            if (c == CH_NUL) begin
               pre_has  = 1'b1;
               pre_res  = make_rsp(KIND_ERR, ERR_OPEN_COMM, cur.tok_start, 8'd0,
                                   cur.tok_line, 8'd0);
               use_idle = 1'b1;
            end else if (c == CH_SLASH && cur.star_seen) begin
               nx.star_seen = 1'b0;
               nx.mode      = MODE_IDLE;
            end else begin
               nx.star_seen = (c == CH_STAR);
            end
         end
         MODE_NUM: begin
            if (is_digit(c)) begin
               nx = grow(cur);
            end else begin
               pre_has      = 1'b1;
               pre_res.kind = KIND_NUM;
               pre_res.err  = tok_err;
               use_idle     = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               nx = ident_byte(cur, c);
            end else begin
               pre_has      = 1'b1;
               pre_res.kind = id_kind;
               pre_res.err  = tok_err;
               use_idle     = 1'b1;
            end
         end
         MODE_STR, MODE_CHR: begin
            if (c == CH_NUL) begin
               pre_has     = 1'b1;
               pre_res.err = (cur.mode == MODE_STR) ? ERR_OPEN_STR : ERR_OPEN_CHR;
               use_idle    = 1'b1;
            end else if (c == ((cur.mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
               pre_has      = 1'b1;
               pre_res.kind = (cur.mode == MODE_STR) ? KIND_STR : KIND_CHR;
               pre_res.err  = tok_err;
               nx.mode      = MODE_IDLE;
            end else begin
               nx = grow(cur);
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase
      if (use_idle) begin
         nx = idle_st;
      end

      // position and line counters, end of text starts over
      if (c == CH_NUL) begin
         nx = SCAN_RESET;
      end else begin
         if (c == CH_NL && nx.line_cnt < LINE_MAX) begin
            nx.line_cnt = nx.line_cnt + 16'd1;
         end
         if (nx.byte_pos < POS_MAX) begin
            nx.byte_pos = nx.byte_pos + 24'd1;
         end
      end

      // order the results of this byte
      out_c.r0  = pre_res;
      out_c.r1  = idle_res;
      out_c.cnt = 2'd0;
      if (pre_has) begin
         if (use_idle && idle_has) begin
            out_c.cnt     = 2'd2;
            out_c.r1.last = 1'b1;
         end else begin
            out_c.cnt     = 2'd1;
            out_c.r0.last = 1'b1;
         end
      end else if (use_idle && idle_has) begin
         out_c.r0      = idle_res;
         out_c.r0.last = 1'b1;
         out_c.cnt     = 2'd1;
      end

      state_in = step_valid ? nx : state_ff;
      scan_out = out_c;
      if (!step_valid) begin
         scan_out.cnt = 2'd0;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/c_subset_token_scanner.sv
// Token scanner for a small C subset.
// The req_ channel takes one source byte per word; a zero byte ends the text,
// emits an EOF token and starts the next text at position 0, line 1.
// The rsp_ channel returns one token or error per word; tuser carries the
// token kind and tlast marks the last result caused by one source byte.
// A byte is scanned in the cycle it is accepted and its results sit in a
// four-entry result queue, so the first one reaches rsp_ at the earliest in
// the cycle after the byte was accepted. A token is emitted only once the
// byte that ends it arrives, and a '/' waits for the following byte.
// One byte per cycle is accepted while the queue has room for two results;
// a byte gives zero, one or two results, and the output drains one result
// per cycle while rsp_tready is high, so a sustained stream of result-heavy
// bytes runs at the rate the queue drains.
// When the receiver stalls, the queue fills and req_tready drops; no result
// is lost. Reset empties the queue and returns the scanner to line 1,
// position 0, between tokens.
module c_subset_token_scanner
   import cst_pkg::*;
#(
   parameter int MAX_LEXEME = CST_MAX_LEXEME
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // error_code[2:0], start_pos[26:3], length[34:27],
                                    // start_line[50:35], bad_char[58:51], zero[63:59]
   output logic [4:0]  rsp_tuser,   // kind[4:0]
   output logic        rsp_tlast
);

   scan_out_type           scan_out;
   logic                   step_valid;
   logic                   pop;
   tok_rsp_type            rsp_q [RSP_DEPTH];
   tok_rsp_type            head;
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;

   // handshakes
   assign req_tready = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign step_valid = req_tvalid & req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid & rsp_tready;

   cst_scan #(
      .MAX_LEXEME (MAX_LEXEME)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_ch    (req_tdata),
      .scan_out   (scan_out)
   );

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = RSP_PTR_W'(wr_ptr_ff + RSP_PTR_W'(scan_out.cnt));
      rd_ptr_in = pop ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = RSP_CNT_W'(count_ff + RSP_CNT_W'(scan_out.cnt) - RSP_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, up to two results written per cycle
   always_ff @(posedge clock) begin
      if (scan_out.cnt != 2'd0) begin
         rsp_q[wr_ptr_ff] <= scan_out.r0;
      end
      if (scan_out.cnt == 2'd2) begin
         rsp_q[RSP_PTR_W'(wr_ptr_ff + 1'b1)] <= scan_out.r1;
      end
   end

   // output word
   assign head      = rsp_q[rd_ptr_ff];
   assign rsp_tdata = {5'd0, head.bad_char, head.start_line, head.length, head.start_pos,
                       head.err};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_eof_result : assert property (@(posedge clock) disable iff (reset)
      step_valid && req_tdata == CH_NUL |=> rsp_tvalid)
      else $error("end of text gave no result");

   a_eof_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EOF |-> rsp_tlast)
      else $error("eof token not last of its byte");

   a_err_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ERR_UNEXPECTED |-> rsp_tuser == KIND_ERR)
      else $error("unexpected char without error kind");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      scan_out.cnt != 2'd0 |-> count_ff <= RSP_CNT_W'(RSP_DEPTH - 2))
      else $error("results pushed without queue room");

endmodule
